// File: hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// shared types and constants of the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int LOC_W   = 11;
	localparam int CELL_W  = 16;
	localparam int IDX_W   = 11;
	localparam int CHAR_W  = 8;
	localparam int COLOR_W = 4;
	localparam int TDATA_W = 32;
	localparam int TUSER_W = 2;

	localparam logic [CELL_W-1:0] BLANK_CELL  = 16'h0F20;
	localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7F;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef enum logic {
		SW_CLEAR  = 1'b0,
		SW_SCROLL = 1'b1
	} sweep_t;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_SWEEP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic take;
		logic sweep_run;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic need_sweep;
		logic sweep_last;
		logic out_free;
	} sts_t;

endpackage

// File: hdl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// sequencer: request intake, screen sweeps and result hand-off
// ----------------------------------------------------------------------------
module tcw_ctrl
	import tcw_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   s_tvalid,
	output logic   s_tready,
	input  sts_t   sts,
	output cmd_t   cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_INIT: begin
				if (sts.sweep_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					state_nxt = sts.need_sweep ? ST_SWEEP : ST_DONE;
				end
			end
			ST_SWEEP: begin
				if (sts.sweep_last) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_INIT;
		endcase
	end

	always_comb begin
		s_tready      = 1'b0;
		cmd.take      = 1'b0;
		cmd.sweep_run = 1'b0;
		cmd.out_load  = 1'b0;
		case (state_q)
			ST_INIT: begin
				cmd.sweep_run = 1'b1;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.take = s_tvalid;
			end
			ST_SWEEP: begin
				cmd.sweep_run = 1'b1;
			end
			ST_DONE: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

// File: hdl/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath
// screen memory, cursor registers, sweep counter and result register
// ----------------------------------------------------------------------------
module tcw_datapath
	import tcw_pkg::*;
#(
	parameter int COLUMNS   = 80,
	parameter int ROWS      = 25,
	parameter int TAB_WIDTH = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  op_t                 op,
	input  logic [CHAR_W-1:0]   char_code,
	input  logic [COLOR_W-1:0]  bg_color,
	input  logic [COLOR_W-1:0]  fg_color,
	input  logic [IDX_W-1:0]    cell_index,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [TDATA_W-1:0]  m_tdata
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int SW    = AW + 1;
	localparam int IW    = (AW > IDX_W) ? AW : IDX_W;
	localparam int LW    = (AW > LOC_W) ? AW : LOC_W;
	localparam int CW    = $clog2(COLUMNS);
	localparam int CNW   = $clog2(COLUMNS + TAB_WIDTH);
	localparam int RW    = $clog2(ROWS);
	localparam int RNW   = $clog2(ROWS + 1);
	localparam int NT    = (COLUMNS + TAB_WIDTH - 1) / TAB_WIDTH;

	logic [CELL_W-1:0] mem [CELLS];
	logic [CELL_W-1:0] rd_q;

	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	logic [AW-1:0]     cnt_q;
	sweep_t            mode_q;
	logic              wr_s1;
	logic [AW-1:0]     waddr_s1;
	logic              blank_s1;
	logic              res_rd_q;
	logic              m_valid_q;
	logic [LOC_W-1:0]  loc_q;
	logic [CELL_W-1:0] cell_q;

	logic [AW-1:0]     pos;
	logic [LW-1:0]     loc_w;
	logic [IW-1:0]     idx_w;
	logic              in_range;
	logic [SW-1:0]     src;
	logic              src_ok;
	logic [CNW-1:0]    col_w;
	logic [CNW-1:0]    col_n;
	logic [CNW-1:0]    tab_next;
	logic [RNW-1:0]    row_n;
	logic              printable;
	logic              scroll_need;
	logic [CW-1:0]     col_fin;
	logic [RW-1:0]     row_fin;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [CELL_W-1:0] wdata;
	logic              re;
	logic [AW-1:0]     raddr;

	// cursor arithmetic
	assign pos       = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
	assign loc_w     = LW'(pos);
	assign idx_w     = IW'(cell_index);
	assign in_range  = idx_w < IW'(CELLS);
	assign src       = SW'(cnt_q) + SW'(COLUMNS);
	assign src_ok    = src < SW'(CELLS);
	assign col_w     = CNW'(col_q);
	assign printable = char_code inside {[CH_PRINT_LO:CH_PRINT_HI]};

	always_comb begin
		tab_next = col_w;
		for (int k = NT; k >= 1; k--) begin
			if (CNW'(k * TAB_WIDTH) > col_w) begin
				tab_next = CNW'(k * TAB_WIDTH);
			end
		end
	end

	always_comb begin
		col_n = col_w;
		row_n = RNW'(row_q);
		case (char_code)
			CH_BS: begin
				if (col_w != '0) begin
					col_n = col_w - CNW'(1);
				end
			end
			CH_TAB: begin
				col_n = tab_next;
			end
			CH_CR: begin
				col_n = '0;
			end
			CH_LF: begin
				col_n = '0;
				row_n = RNW'(row_q) + RNW'(1);
			end
			default: begin
				if (printable) begin
					col_n = col_w + CNW'(1);
				end
			end
		endcase
		if (col_n >= CNW'(COLUMNS)) begin
			col_n = '0;
			row_n = row_n + RNW'(1);
		end
		scroll_need = row_n == RNW'(ROWS);
		col_fin     = col_n[CW-1:0];
		row_fin     = scroll_need ? RW'(ROWS - 1) : row_n[RW-1:0];
	end

	always_comb begin
		sts.need_sweep = (op == OP_CLEAR) || ((op == OP_PUT) && scroll_need);
		sts.sweep_last = cnt_q == AW'(CELLS - 1);
		sts.out_free   = !m_valid_q || m_tready;
	end

	// cursor and request registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			mode_q <= SW_CLEAR;
		end else if (cmd.take) begin
			mode_q <= (op == OP_CLEAR) ? SW_CLEAR : SW_SCROLL;
			case (op)
				OP_PUT: begin
					col_q <= col_fin;
					row_q <= row_fin;
				end
				OP_CLEAR: begin
					col_q <= '0;
					row_q <= '0;
				end
				default: begin
					col_q <= col_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			res_rd_q <= (op == OP_READ) && in_range;
		end
	end

	// sweep counter and scroll copy pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_s1 <= 1'b0;
		end else begin
			wr_s1 <= cmd.sweep_run && (mode_q == SW_SCROLL);
			if (cmd.sweep_run) begin
				cnt_q <= sts.sweep_last ? '0 : cnt_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= cnt_q;
		blank_s1 <= !src_ok;
	end

	// memory ports
	always_comb begin
		we    = 1'b0;
		waddr = pos;
		wdata = {bg_color, fg_color, char_code};
		if (wr_s1) begin
			we    = 1'b1;
			waddr = waddr_s1;
			wdata = blank_s1 ? BLANK_CELL : rd_q;
		end else if (cmd.sweep_run && (mode_q == SW_CLEAR)) begin
			we    = 1'b1;
			waddr = cnt_q;
			wdata = BLANK_CELL;
		end else if (cmd.take && (op == OP_PUT) && printable) begin
			we = 1'b1;
		end
	end

	assign re    = (cmd.take && (op == OP_READ) && in_range)
		|| (cmd.sweep_run && (mode_q == SW_SCROLL) && src_ok);
	assign raddr = cmd.take ? idx_w[AW-1:0] : src[AW-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			loc_q  <= loc_w[LOC_W-1:0];
			cell_q <= res_rd_q ? rd_q : '0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(TDATA_W - LOC_W - CELL_W)'(0), cell_q, loc_q};

	cursor_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= RW'(ROWS - 1))
		else $error("cursor row beyond last row");

	cursor_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= CW'(COLUMNS - 1))
		else $error("cursor column beyond last column");

	sweep_counter_parked: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.sweep_run |-> cnt_q == '0)
		else $error("sweep counter moved outside a sweep");

	no_request_during_copy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_s1 |-> !cmd.take)
		else $error("request taken while scroll copy still writing");

endmodule

// File: hdl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// character-cell text console with cursor, scroll, clear and cell readback
// ----------------------------------------------------------------------------
//  channel   dir  tdata / tuser                                 one request
//  s_*       in   char_code, bg_color, fg_color, cell_index      put/clear/read
//                 tuser: op
//  m_*       out  cursor_location, cell_data                     one result
//
//  put (no scroll), read and unused op: no sweep, straight from request to result
//  scroll and clear: a sweep over all COLUMNS*ROWS cells, one screen cell a cycle
//  through the single write port of the screen memory
//  after reset a blanking pass over all COLUMNS*ROWS cells runs with s_tready low
//  one request at a time; the next is taken while the last result waits
//  a stalled m side holds the block after the following request's work
// ----------------------------------------------------------------------------
module text_console_writer
	import tcw_pkg::*;
#(
	parameter int COLUMNS   = 80,
	parameter int ROWS      = 25,
	parameter int TAB_WIDTH = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [TDATA_W-1:0]  s_tdata,  // char_code, bg_color, fg_color, cell_index
	input  logic [TUSER_W-1:0]  s_tuser,  // op
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [TDATA_W-1:0]  m_tdata   // cursor_location, cell_data
);

	cmd_t cmd;
	sts_t sts;

	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tcw_datapath #(
		.COLUMNS   (COLUMNS),
		.ROWS      (ROWS),
		.TAB_WIDTH (TAB_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.op         (op_t'(s_tuser)),
		.char_code  (s_tdata[7:0]),
		.bg_color   (s_tdata[11:8]),
		.fg_color   (s_tdata[15:12]),
		.cell_index (s_tdata[26:16]),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule
